@@ hdl/rgb2yuv_pkg.sv @@
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
`default_nettype none

package rgb2yuv_pkg;

  // Field widths
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int LUMA_IDX_W   = 24;
  localparam int CHROMA_IDX_W = 22;
  localparam int SUM_W        = 18;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

  // Reset values of the size registers
  localparam logic [CFG_W-1:0] RESET_SRC_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RESET_SRC_HEIGHT = 13'd1080;

  // BT.601 studio range coefficients
  localparam logic signed [SUM_W-1:0] C_YR  = 18'sd66;
  localparam logic signed [SUM_W-1:0] C_YG  = 18'sd129;
  localparam logic signed [SUM_W-1:0] C_YB  = 18'sd25;
  localparam logic signed [SUM_W-1:0] C_UR  = -18'sd38;
  localparam logic signed [SUM_W-1:0] C_UG  = -18'sd74;
  localparam logic signed [SUM_W-1:0] C_UB  = 18'sd112;
  localparam logic signed [SUM_W-1:0] C_VR  = 18'sd112;
  localparam logic signed [SUM_W-1:0] C_VG  = -18'sd94;
  localparam logic signed [SUM_W-1:0] C_VB  = -18'sd18;
  localparam logic signed [SUM_W-1:0] C_RND = 18'sd128;
  localparam logic [PIX_W-1:0] Y_OFFSET = 8'd16;
  localparam logic [PIX_W-1:0] C_OFFSET = 8'd128;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified pixel request
  typedef struct packed {
    logic [PIX_W-1:0]        red;
    logic [PIX_W-1:0]        green;
    logic [PIX_W-1:0]        blue;
    logic                    kept;
    logic                    chroma_valid;
    logic                    frame_end;
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic [CHROMA_IDX_W-1:0] chroma_index;
  } pix_req_t;

endpackage

`default_nettype wire

@@ hdl/rgb2yuv_front.sv @@
// Front end: size registers, raster position tracking and pixel classification.
`default_nettype none

module rgb2yuv_front
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int CROP_ALIGN = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 push,
  input  wire logic [PIX_W-1:0]     red,
  input  wire logic [PIX_W-1:0]     green,
  input  wire logic [PIX_W-1:0]     blue,
  input  wire logic                 q_full,
  output logic                      q_push,
  output pix_req_t                  q_req
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W = (WSZ_W > CFG_W) ? WSZ_W : CFG_W;
  localparam int HCMP_W = (HSZ_W > CFG_W) ? HSZ_W : CFG_W;
  localparam int WEXT_W = WSZ_W + 7;
  localparam int HEXT_W = HSZ_W + 7;
  localparam int SUB_W  = (CROP_ALIGN > 1) ? $clog2(CROP_ALIGN) : 1;

  logic [CFG_W-1:0]        src_width_r;
  logic [CFG_W-1:0]        src_height_r;
  logic [COL_W-1:0]        col_r;
  logic [COL_W-1:0]        col_base_r;
  logic [SUB_W-1:0]        col_sub_r;
  logic [ROW_W-1:0]        row_r;
  logic [ROW_W-1:0]        row_base_r;
  logic [SUB_W-1:0]        row_sub_r;
  logic [LUMA_IDX_W-1:0]   luma_cnt_r;
  logic [CHROMA_IDX_W-1:0] chroma_cnt_r;

  logic [WSZ_W-1:0] w_eff;
  logic [HSZ_W-1:0] h_eff;
  logic             last_col;
  logic             last_row;
  logic             kept;
  logic             cvalid;
  logic             accept;

  // Effective frame size: zero acts as one, oversize clamps to the maximum
  assign w_eff = (src_width_r == '0) ? WSZ_W'(1) :
                 (WCMP_W'(src_width_r) > WCMP_W'(MAX_WIDTH)) ? WSZ_W'(MAX_WIDTH) :
                 WSZ_W'(src_width_r);
  assign h_eff = (src_height_r == '0) ? HSZ_W'(1) :
                 (HCMP_W'(src_height_r) > HCMP_W'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) :
                 HSZ_W'(src_height_r);

  // Classification: an aligned block is kept when it fits fully inside the frame
  assign last_col = (WSZ_W'(col_r) == (w_eff - WSZ_W'(1)));
  assign last_row = (HSZ_W'(row_r) == (h_eff - HSZ_W'(1)));
  assign kept     = ((WEXT_W'(col_base_r) + WEXT_W'(CROP_ALIGN)) <= WEXT_W'(w_eff)) &&
                    ((HEXT_W'(row_base_r) + HEXT_W'(CROP_ALIGN)) <= HEXT_W'(h_eff));
  assign cvalid   = kept && col_r[0] && row_r[0];

  assign accept = push && !q_full;
  assign q_push = accept;

  // Kept pixels are consecutive in the cropped planes, so indexes are running counts
  always_comb begin
    q_req              = '0;
    q_req.red          = red;
    q_req.green        = green;
    q_req.blue         = blue;
    q_req.kept         = kept;
    q_req.chroma_valid = cvalid;
    q_req.frame_end    = last_col && last_row;
    if (kept) begin
      q_req.luma_index = luma_cnt_r;
    end
    if (cvalid) begin
      q_req.chroma_index = chroma_cnt_r;
    end
  end

  // Size registers and position counters; a size write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RESET_SRC_WIDTH;
      src_height_r <= RESET_SRC_HEIGHT;
      col_r        <= '0;
      col_base_r   <= '0;
      col_sub_r    <= '0;
      row_r        <= '0;
      row_base_r   <= '0;
      row_sub_r    <= '0;
      luma_cnt_r   <= '0;
      chroma_cnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
      endcase
      col_r        <= '0;
      col_base_r   <= '0;
      col_sub_r    <= '0;
      row_r        <= '0;
      row_base_r   <= '0;
      row_sub_r    <= '0;
      luma_cnt_r   <= '0;
      chroma_cnt_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r      <= '0;
        col_base_r <= '0;
        col_sub_r  <= '0;
        if (last_row) begin
          row_r      <= '0;
          row_base_r <= '0;
          row_sub_r  <= '0;
        end else begin
          row_r <= row_r + ROW_W'(1);
          if (row_sub_r == SUB_W'(CROP_ALIGN - 1)) begin
            row_sub_r  <= '0;
            row_base_r <= row_r + ROW_W'(1);
          end else begin
            row_sub_r <= row_sub_r + SUB_W'(1);
          end
        end
      end else begin
        col_r <= col_r + COL_W'(1);
        if (col_sub_r == SUB_W'(CROP_ALIGN - 1)) begin
          col_sub_r  <= '0;
          col_base_r <= col_r + COL_W'(1);
        end else begin
          col_sub_r <= col_sub_r + SUB_W'(1);
        end
      end
      // plane counters restart with each frame
      if (last_col && last_row) begin
        luma_cnt_r   <= '0;
        chroma_cnt_r <= '0;
      end else begin
        if (kept) begin
          luma_cnt_r <= luma_cnt_r + LUMA_IDX_W'(1);
        end
        if (cvalid) begin
          chroma_cnt_r <= chroma_cnt_r + CHROMA_IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rgb2yuv_queue.sv @@
// Short request queue between the front end and the color back end.
`default_nettype none

module rgb2yuv_queue
  import rgb2yuv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_push,
  input  wire pix_req_t q_wdata,
  output logic          q_full,
  input  wire logic     q_pop,
  output pix_req_t      q_rdata,
  output logic          q_empty
);

  pix_req_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_r;
  logic [QUEUE_PTR_W-1:0]  rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]  count_r;
  logic                    do_push;
  logic                    do_pop;

  assign q_full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                    wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                    rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rgb2yuv_back.sv @@
// Back end: BT.601 multiply-add stage, scaling stage and result register.
`default_nettype none

module rgb2yuv_back
  import rgb2yuv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire pix_req_t                q_rdata,
  input  wire logic                    q_empty,
  output logic                         q_pop,
  input  wire logic                    pop,
  output logic                         empty,
  output logic                         kept,
  output logic [PIX_W-1:0]             luma,
  output logic [LUMA_IDX_W-1:0]        luma_index,
  output logic                         chroma_valid,
  output logic [PIX_W-1:0]             cb,
  output logic [PIX_W-1:0]             cr,
  output logic [CHROMA_IDX_W-1:0]      chroma_index,
  output logic                         frame_end
);

  // Divide by 256 truncating toward zero, add offset, keep low byte
  function automatic logic [PIX_W-1:0] scale_offset(input logic signed [SUM_W-1:0] s,
                                                    input logic [PIX_W-1:0] off);
    logic signed [SUM_W-1:0] adj;
    logic signed [SUM_W-1:0] q;
    adj = s + (s[SUM_W-1] ? 18'sd255 : 18'sd0);
    q   = adj >>> 8;
    return q[PIX_W-1:0] + off;
  endfunction

  logic                    s1_v_r;
  pix_req_t                s1_req_r;
  logic signed [SUM_W-1:0] s1_y_r;
  logic signed [SUM_W-1:0] s1_u_r;
  logic signed [SUM_W-1:0] s1_v_sum_r;
  logic                    out_v_r;

  logic signed [SUM_W-1:0] r_s;
  logic signed [SUM_W-1:0] g_s;
  logic signed [SUM_W-1:0] b_s;
  logic                    out_adv;
  logic                    s1_adv;

  // Stall chain from the result register back to the queue
  assign out_adv = !out_v_r || pop;
  assign s1_adv  = !s1_v_r || out_adv;
  assign q_pop   = !q_empty && s1_adv;
  assign empty   = !out_v_r;

  assign r_s = $signed({{(SUM_W - PIX_W){1'b0}}, q_rdata.red});
  assign g_s = $signed({{(SUM_W - PIX_W){1'b0}}, q_rdata.green});
  assign b_s = $signed({{(SUM_W - PIX_W){1'b0}}, q_rdata.blue});

  // Stage 1: weighted sums
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_req_r   <= q_rdata;
      s1_y_r     <= C_YR * r_s + C_YG * g_s + C_YB * b_s + C_RND;
      s1_u_r     <= C_UR * r_s + C_UG * g_s + C_UB * b_s + C_RND;
      s1_v_sum_r <= C_VR * r_s + C_VG * g_s + C_VB * b_s + C_RND;
    end
  end

  // Stage 2: scaling and zeroing of fields that do not apply
  always_ff @(posedge clk) begin
    if (out_adv) begin
      kept         <= s1_req_r.kept;
      luma_index   <= s1_req_r.luma_index;
      chroma_valid <= s1_req_r.chroma_valid;
      chroma_index <= s1_req_r.chroma_index;
      frame_end    <= s1_req_r.frame_end;
      luma         <= s1_req_r.kept ? scale_offset(s1_y_r, Y_OFFSET) : '0;
      cb           <= s1_req_r.chroma_valid ? scale_offset(s1_u_r, C_OFFSET) : '0;
      cr           <= s1_req_r.chroma_valid ? scale_offset(s1_v_sum_r, C_OFFSET) : '0;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= !q_empty;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rgb2yuv_to_yuv420_planar_converter_core.sv @@
// Top level of the RGB to YCbCr 4:2:0 planar converter.
`default_nettype none

// Converts raster-order RGB pixels to BT.601 studio-range luma and 4:2:0 chroma with
// plane indexes, one pixel per clock sustained while the queue is not full and results
// are popped. Each accepted pixel gives exactly one result; it passes through the queue
// entry, the multiply-add stage register and the scaling stage (result) register, and
// the multiply-add stage takes a new request every clock unless the result register is
// held. A two-entry request queue lets the input keep accepting while results wait to
// be popped. Pixels outside the frame cropped down to multiples of CROP_ALIGN are marked
// not kept; chroma is sampled from the bottom-right pixel of each 2x2 quad. Writing
// either size register restarts the frame at column 0, row 0. The user must ensure sizes
// are written only while the block is idle; the block itself does not enforce this.
module rgb_to_yuv420_planar_converter_core
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int CROP_ALIGN = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  // pixel input
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [PIX_W-1:0]        in_red,
  input  wire logic [PIX_W-1:0]        in_green,
  input  wire logic [PIX_W-1:0]        in_blue,
  // results
  output logic                         empty,
  input  wire logic                    pop,
  output logic                         out_kept,
  output logic [PIX_W-1:0]             out_luma,
  output logic [LUMA_IDX_W-1:0]        out_luma_index,
  output logic                         out_chroma_valid,
  output logic [PIX_W-1:0]             out_cb,
  output logic [PIX_W-1:0]             out_cr,
  output logic [CHROMA_IDX_W-1:0]      out_chroma_index,
  output logic                         out_frame_end
);

  pix_req_t q_wdata;
  pix_req_t q_rdata;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  assign full = q_full;

  rgb2yuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CROP_ALIGN (CROP_ALIGN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (q_wdata)
  );

  rgb2yuv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  rgb2yuv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_rdata      (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kept         (out_kept),
    .luma         (out_luma),
    .luma_index   (out_luma_index),
    .chroma_valid (out_chroma_valid),
    .cb           (out_cb),
    .cr           (out_cr),
    .chroma_index (out_chroma_index),
    .frame_end    (out_frame_end)
  );

  // Front never writes a full queue, back never reads an empty one
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request written into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request read from empty queue");

  // Dropped pixels carry no samples or indexes
  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_kept) |-> (out_luma == '0 && out_luma_index == '0 &&
                               !out_chroma_valid))
    else $error("dropped pixel has nonzero fields");

  // Chroma only from kept pixels, zero otherwise
  a_chroma_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_chroma_valid) |-> (out_cb == '0 && out_cr == '0 &&
                                       out_chroma_index == '0))
    else $error("chroma fields set without chroma");

endmodule

`default_nettype wire

@@ tb/yuv420_result_checker.sv @@
// Checker for the RGB to YCbCr 4:2:0 converter: watches all ports, predicts and compares.
`timescale 1ns / 100ps

module yuv420_result_checker
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int CROP_ALIGN = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  input  wire logic                    push,
  input  wire logic                    full,
  input  wire logic [PIX_W-1:0]        in_red,
  input  wire logic [PIX_W-1:0]        in_green,
  input  wire logic [PIX_W-1:0]        in_blue,
  input  wire logic                    empty,
  input  wire logic                    pop,
  input  wire logic                    out_kept,
  input  wire logic [PIX_W-1:0]        out_luma,
  input  wire logic [LUMA_IDX_W-1:0]   out_luma_index,
  input  wire logic                    out_chroma_valid,
  input  wire logic [PIX_W-1:0]        out_cb,
  input  wire logic [PIX_W-1:0]        out_cr,
  input  wire logic [CHROMA_IDX_W-1:0] out_chroma_index,
  input  wire logic                    out_frame_end,
  output int unsigned                  fail_count,
  output int unsigned                  pending,
  output int unsigned                  checked_count,
  output int unsigned                  chroma_count,
  output int unsigned                  frame_count
);

  // One converted pixel as the block should report it
  typedef struct packed {
    logic                    kept;
    logic [PIX_W-1:0]        luma;
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic                    chroma_valid;
    logic [PIX_W-1:0]        cb;
    logic [PIX_W-1:0]        cr;
    logic [CHROMA_IDX_W-1:0] chroma_index;
    logic                    frame_end;
  } yuv_sample_t;

  // Shadow of the size registers and the raster position
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;

  yuv_sample_t expected_samples[$];

  // Register value 0 acts as 1, anything above the maximum acts as the maximum
  function automatic int unsigned active_size(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Divide by 256 truncating toward zero (int division does), then add offset
  function automatic logic [PIX_W-1:0] scale_offset(int sum, int offset);
    int q;
    q = sum / 256;
    return PIX_W'(q + offset);
  endfunction

  function automatic yuv_sample_t convert_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                                                logic [PIX_W-1:0] blue, int unsigned col,
                                                int unsigned row, int unsigned w,
                                                int unsigned h);
    yuv_sample_t s;
    int unsigned cw;
    int unsigned ch;
    int          r;
    int          g;
    int          b;
    s  = '0;
    cw = w - (w % CROP_ALIGN);
    ch = h - (h % CROP_ALIGN);
    r  = red;
    g  = green;
    b  = blue;
    s.kept      = (col < cw) && (row < ch);
    s.frame_end = (col == w - 1) && (row == h - 1);
    if (s.kept) begin
      s.luma       = scale_offset(66 * r + 129 * g + 25 * b + 128, 16);
      s.luma_index = LUMA_IDX_W'(col + row * cw);
      // chroma taken from the bottom-right pixel of each 2x2 quad
      if (col[0] && row[0]) begin
        s.chroma_valid = 1'b1;
        s.cb = scale_offset(-38 * r - 74 * g + 112 * b + 128, 128);
        s.cr = scale_offset(112 * r - 94 * g - 18 * b + 128, 128);
        s.chroma_index = CHROMA_IDX_W'((col >> 1) + (row >> 1) * (cw >> 1));
      end
    end
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_edge
    int unsigned w;
    int unsigned h;
    yuv_sample_t want;
    if (!rst_n) begin
      width_reg     = RESET_SRC_WIDTH;
      height_reg    = RESET_SRC_HEIGHT;
      col_pos       = 0;
      row_pos       = 0;
      fail_count    = 0;
      checked_count = 0;
      chroma_count  = 0;
      frame_count   = 0;
      expected_samples.delete();
    end else begin
      // size write restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH: begin
            width_reg = cfg_wdata;
            col_pos   = 0;
            row_pos   = 0;
          end
          REG_SRC_HEIGHT: begin
            height_reg = cfg_wdata;
            col_pos    = 0;
            row_pos    = 0;
          end
          default: ;
        endcase
      end

      // accepted pixel request: predict and advance the raster position
      if (push && !full) begin
        w = active_size(width_reg, MAX_WIDTH);
        h = active_size(height_reg, MAX_HEIGHT);
        if (col_pos >= w) col_pos = w - 1;
        if (row_pos >= h) row_pos = h - 1;
        expected_samples.push_back(convert_pixel(in_red, in_green, in_blue,
                                                 col_pos, row_pos, w, h));
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= h) row_pos = 0;
        end
      end

      // accepted result request: compare with the oldest prediction
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          $error("result request with no pixel outstanding");
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          check_field("kept", want.kept, out_kept);
          check_field("luma", want.luma, out_luma);
          check_field("luma_index", want.luma_index, out_luma_index);
          check_field("chroma_valid", want.chroma_valid, out_chroma_valid);
          check_field("cb", want.cb, out_cb);
          check_field("cr", want.cr, out_cr);
          check_field("chroma_index", want.chroma_index, out_chroma_index);
          check_field("frame_end", want.frame_end, out_frame_end);
          checked_count++;
          if (want.chroma_valid) chroma_count++;
          if (want.frame_end) frame_count++;
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the converter testbench: clock, reset, pixel and config stimulus, verdict.
`timescale 1ns / 100ps

module tb_top;
  import rgb2yuv_pkg::*;

  localparam int MAX_W      = 4096;
  localparam int MAX_H      = 4096;
  localparam int ALIGN      = 16;
  localparam int RAND_ITEMS = 1350;
  localparam int CALM_ITEMS = 120;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    push;
  logic                    full;
  logic [PIX_W-1:0]        in_red;
  logic [PIX_W-1:0]        in_green;
  logic [PIX_W-1:0]        in_blue;
  logic                    empty;
  logic                    pop;
  logic                    out_kept;
  logic [PIX_W-1:0]        out_luma;
  logic [LUMA_IDX_W-1:0]   out_luma_index;
  logic                    out_chroma_valid;
  logic [PIX_W-1:0]        out_cb;
  logic [PIX_W-1:0]        out_cr;
  logic [CHROMA_IDX_W-1:0] out_chroma_index;
  logic                    out_frame_end;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked_count;
  int unsigned chroma_count;
  int unsigned frame_count;

  // idle controls shared by both sides; calm turns all idling off
  bit          calm;
  int unsigned push_idle_pct;
  int unsigned pop_idle_pct;
  int unsigned sent_count;
  int unsigned setting_count;

  rgb_to_yuv420_planar_converter_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .CROP_ALIGN(ALIGN)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .empty           (empty),
    .pop             (pop),
    .out_kept        (out_kept),
    .out_luma        (out_luma),
    .out_luma_index  (out_luma_index),
    .out_chroma_valid(out_chroma_valid),
    .out_cb          (out_cb),
    .out_cr          (out_cr),
    .out_chroma_index(out_chroma_index),
    .out_frame_end   (out_frame_end)
  );

  yuv420_result_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .CROP_ALIGN(ALIGN)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .empty           (empty),
    .pop             (pop),
    .out_kept        (out_kept),
    .out_luma        (out_luma),
    .out_luma_index  (out_luma_index),
    .out_chroma_valid(out_chroma_valid),
    .out_cb          (out_cb),
    .out_cr          (out_cr),
    .out_chroma_index(out_chroma_index),
    .out_frame_end   (out_frame_end),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked_count   (checked_count),
    .chroma_count    (chroma_count),
    .frame_count     (frame_count)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // result side: pop with random stall bursts
  initial begin : pop_side
    int unsigned stall;
    stall = 0;
    pop   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall == 0 && !calm && $urandom_range(0, 99) < pop_idle_pct)
        stall = $urandom_range(1, 18);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // biased toward the extremes of the component range
  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly frames a little above the alignment, some tiny or out of range
  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CFG_W'(ALIGN + $urandom_range(0, 5));
      5:             return CFG_W'($urandom_range(1, ALIGN - 1));
      6:             return CFG_W'(2 * ALIGN + $urandom_range(0, 3));
      7:             return '0;
      8:             return CFG_W'(MAX_W);
      default:       return CFG_W'($urandom_range(MAX_W + 1, 8191));
    endcase
  endfunction

  function automatic int unsigned active_dim(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // one pixel request; called and returns at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    if (!calm && $urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    push     <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  // stop pushing and wait until every result is back, plus pipeline slack
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // size writes, back to back; write enable only drops after the last one
  task automatic set_frame(input bit wr_w, input bit wr_h, input logic [CFG_W-1:0] w,
                           input logic [CFG_W-1:0] h);
    if (wr_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SRC_WIDTH;
      cfg_wdata <= w;
      @(negedge clk);
    end
    if (wr_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SRC_HEIGHT;
      cfg_wdata <= h;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] corner_r[8];
    logic [PIX_W-1:0] corner_g[8];
    logic [PIX_W-1:0] corner_b[8];
    logic [CFG_W-1:0] cur_w;
    logic [CFG_W-1:0] cur_h;
    logic [CFG_W-1:0] new_w;
    logic [CFG_W-1:0] new_h;
    bit               wr_w;
    bit               wr_h;
    int unsigned      frame_px;
    int unsigned      n;
    int unsigned      remaining;

    cfg_we        = 1'b0;
    cfg_index     = REG_SRC_WIDTH;
    cfg_wdata     = '0;
    push          = 1'b0;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    rst_n         = 1'b0;
    calm          = 1'b0;
    push_idle_pct = 10;
    pop_idle_pct  = 10;
    sent_count    = 0;
    setting_count = 0;

    // corners of the RGB cube
    for (int i = 0; i < 8; i++) begin
      corner_r[i] = i[0] ? 8'hFF : 8'h00;
      corner_g[i] = i[1] ? 8'hFF : 8'h00;
      corner_b[i] = i[2] ? 8'hFF : 8'h00;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset size, all cube corners on the first row
    for (int i = 0; i < 8; i++) send_pixel(corner_r[i], corner_g[i], corner_b[i]);
    drain();

    // directed: 16x16, through row 1 so the first chroma quad completes
    set_frame(1'b1, 1'b1, CFG_W'(ALIGN), CFG_W'(ALIGN));
    for (int i = 0; i < ALIGN + 2; i++)
      send_pixel(corner_r[(i + 5) % 8], corner_g[(i + 5) % 8], corner_b[(i + 5) % 8]);
    drain();

    // directed: zero sizes act as 1x1, every pixel dropped and ends a frame
    set_frame(1'b1, 1'b1, '0, '0);
    send_pixel(8'hFF, 8'h00, 8'h80);
    send_pixel(8'h00, 8'hFF, 8'h7F);
    drain();

    // directed: sizes beyond the maximum clamp to it
    set_frame(1'b1, 1'b1, '1, CFG_W'(MAX_H + 1));
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    drain();
    cur_w = '1;
    cur_h = CFG_W'(MAX_H + 1);

    // random phases, each with its own size and idle mix
    remaining = RAND_ITEMS;
    while (remaining > 0) begin
      new_w = pick_size();
      new_h = pick_size();
      case ($urandom_range(0, 5))
        0:       begin wr_w = 1'b1; wr_h = 1'b0; end
        1:       begin wr_w = 1'b0; wr_h = 1'b1; end
        default: begin wr_w = 1'b1; wr_h = 1'b1; end
      endcase
      if (wr_w) cur_w = new_w;
      if (wr_h) cur_h = new_h;
      set_frame(wr_w, wr_h, new_w, new_h);

      frame_px = active_dim(cur_w, MAX_W) * active_dim(cur_h, MAX_H);
      if (frame_px <= 450)
        n = frame_px * $urandom_range(1, 2) + $urandom_range(0, 20);
      else
        n = $urandom_range(30, 150);
      if (n > remaining) n = remaining;

      case ($urandom_range(0, 3))
        0:       begin push_idle_pct = 0;  pop_idle_pct = 0; end
        1:       begin push_idle_pct = $urandom_range(5, 25); pop_idle_pct = 0; end
        2:       begin push_idle_pct = 0; pop_idle_pct = $urandom_range(5, 25); end
        default: begin
          push_idle_pct = $urandom_range(2, 15);
          pop_idle_pct  = $urandom_range(2, 15);
        end
      endcase

      for (int i = 0; i < n; i++) begin
        calm = (remaining <= CALM_ITEMS);
        send_pixel(pick_level(), pick_level(), pick_level());
        remaining--;
      end
      drain();
    end

    $display("Sent %0d pixels over %0d size settings; checked %0d results,",
             sent_count, setting_count, checked_count);
    $display("%0d of them with chroma and %0d at a frame end.", chroma_count, frame_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
